>>> sv/epsd_pkg.sv
// Shared types, constants and calendar helpers for the epoch-to-date converter.
// No dependencies; imported by the controller, the datapath and the top level.
package epsd_pkg;

  localparam int unsigned EpochW    = 32;
  localparam int unsigned OffsetW   = 17;
  localparam int unsigned SumW      = EpochW + 2;  // signed sum, no overflow
  localparam int unsigned TimeW     = EpochW + 1;  // saturated local time
  localparam int unsigned YearW     = 12;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned DayW      = 5;
  localparam int unsigned HourW     = 5;
  localparam int unsigned MinuteW   = 6;
  localparam int unsigned DaysW     = 17;          // whole days since epoch
  localparam int unsigned SodW      = 17;          // seconds within the day
  localparam int unsigned MinOfDayW = 11;          // minutes within the day

  // Division by constants through reciprocal multiplication. Each divisor is
  // split into a power of two, taken by a shift, and an odd factor, taken by
  // multiplying with ceil(2^shift / factor); exact over the whole input range.
  // 86400 = 128 * 675, 3600 = 16 * 225, 60 = 4 * 15.
  localparam int unsigned DayNumW    = TimeW - 7;
  localparam int unsigned DayRecipW  = 27;
  localparam int unsigned DayShift   = 36;
  localparam int unsigned HourNumW   = SodW - 4;
  localparam int unsigned HourRecipW = 14;
  localparam int unsigned HourShift  = 21;
  localparam int unsigned MinNumW    = SodW - 2;
  localparam int unsigned MinRecipW  = 16;
  localparam int unsigned MinShift   = 19;

  localparam logic [DayRecipW-1:0]  DayRecip  = 27'd101806633;
  localparam logic [HourRecipW-1:0] HourRecip = 14'd9321;
  localparam logic [MinRecipW-1:0]  MinRecip  = 16'd34953;

  localparam int unsigned     DaySecsW   = 17;
  localparam logic [DaySecsW-1:0] SecsPerDay = 17'd86400;

  localparam logic [YearW-1:0]   EpochYear      = YearW'(1970);
  localparam logic [YearW-1:0]   CenturyNoLeap  = YearW'(2100);
  localparam logic [MonthW-1:0]  MonthJan       = MonthW'(1);
  localparam logic [MonthW-1:0]  MonthFeb       = MonthW'(2);
  localparam logic [MonthW-1:0]  MonthDec       = MonthW'(12);
  localparam logic [OffsetW-1:0] OffsetReset    = OffsetW'(28800);

  typedef struct packed {
    logic load;
    logic day_quo;
    logic day_rem;
    logic hour_split;
    logic min_split;
    logic year_step;
    logic month_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic year_fits;
    logic month_fits;
  } status_t;

  function automatic logic [8:0] month_days(input logic [MonthW-1:0] m, input logic leap);
    logic [8:0] len;
    case (m)
      MonthFeb:                  len = leap ? 9'd29 : 9'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 9'd30;
      default:                   len = 9'd31;
    endcase
    return len;
  endfunction

endpackage

>>> sv/epsd_ctrl.sv
// Sequencing state machine for the epoch-to-date converter.
// Depends on epsd_pkg; drives the datapath through cmd_t and reads status_t.
module epsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  epsd_pkg::status_t status_i,
  output epsd_pkg::cmd_t    cmd_o
);
  import epsd_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DAY   = 8'b00000010,
    S_REM   = 8'b00000100,
    S_HOUR  = 8'b00001000,
    S_MIN   = 8'b00010000,
    S_YEAR  = 8'b00100000,
    S_MONTH = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_e;

  state_e             state_q, state_d;
  logic               oval_q, oval_d;
  logic               publish;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;
  assign publish     = (state_q == S_DONE) && (!oval_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DAY;
      end
      S_DAY: begin
        state_d = S_REM;
      end
      S_REM: begin
        state_d = S_HOUR;
      end
      S_HOUR: begin
        state_d = S_MIN;
      end
      S_MIN: begin
        state_d = S_YEAR;
      end
      S_YEAR: begin
        if (status_i.year_fits) state_d = S_MONTH;
      end
      S_MONTH: begin
        if (status_i.month_fits) state_d = S_DONE;
      end
      S_DONE: begin
        if (publish) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    oval_d = oval_q;
    if (oval_q && out_ready_i) oval_d = 1'b0;
    if (publish)               oval_d = 1'b1;
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == S_IDLE) && in_valid_i;
    cmd_o.day_quo    = (state_q == S_DAY);
    cmd_o.day_rem    = (state_q == S_REM);
    cmd_o.hour_split = (state_q == S_HOUR);
    cmd_o.min_split  = (state_q == S_MIN);
    cmd_o.year_step  = (state_q == S_YEAR) && !status_i.year_fits;
    cmd_o.month_step = (state_q == S_MONTH) && !status_i.month_fits;
    cmd_o.publish    = publish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

endmodule

>>> sv/epsd_datapath.sv
// Arithmetic for the epoch-to-date converter: offset register, reciprocal
// division by constants, year/month stepping and the result register. Uses epsd_pkg.
module epsd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wen_i,
  input  logic [epsd_pkg::OffsetW-1:0]  cfg_wdata_i,
  input  logic [epsd_pkg::EpochW-1:0]   epoch_i,
  input  epsd_pkg::cmd_t                cmd_i,
  output epsd_pkg::status_t             status_o,
  output logic [epsd_pkg::YearW-1:0]    year_o,
  output logic [epsd_pkg::MonthW-1:0]   month_o,
  output logic [epsd_pkg::DayW-1:0]     day_o,
  output logic [epsd_pkg::HourW-1:0]    hour_o,
  output logic [epsd_pkg::MinuteW-1:0]  minute_o
);
  import epsd_pkg::*;

  logic [OffsetW-1:0]   offset_q;
  logic [TimeW-1:0]     rem_q;
  logic [DaysW-1:0]     days_q;
  logic [HourW-1:0]     hour_q;
  logic [MinOfDayW-1:0] mday_q;
  logic [MinuteW-1:0]   min_q;
  logic [YearW-1:0]     year_q;
  logic [MonthW-1:0]    month_q;

  logic [YearW-1:0]   year_out_q;
  logic [MonthW-1:0]  month_out_q;
  logic [DayW-1:0]    day_out_q;
  logic [HourW-1:0]   hour_out_q;
  logic [MinuteW-1:0] min_out_q;

  logic signed [SumW-1:0]            sum;
  logic [TimeW-1:0]                  local_t;
  logic [DayNumW+DayRecipW-1:0]      day_prod;
  logic [DaysW+DaySecsW-1:0]         day_secs;
  logic [HourNumW+HourRecipW-1:0]    hour_prod;
  logic [MinNumW+MinRecipW-1:0]      mday_prod;
  logic [MinOfDayW-1:0]              hour_mins;
  logic [MinOfDayW-1:0]              min_diff;
  logic                              leap;
  logic [8:0]                        ylen, mlen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (cfg_wen_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // Clamp a negative local time to the epoch itself
  assign sum     = $signed({2'b00, epoch_i}) + $signed({{(SumW-OffsetW){offset_q[OffsetW-1]}},
                                                        offset_q});
  assign local_t = sum[SumW-1] ? '0 : sum[TimeW-1:0];

  // Whole days: drop the factor 128 by a shift, then divide by 675
  assign day_prod = rem_q[TimeW-1:7] * DayRecip;
  assign day_secs = days_q * SecsPerDay;

  // Hour and minute of day from the seconds left within the day
  assign hour_prod = rem_q[SodW-1:4] * HourRecip;
  assign mday_prod = rem_q[SodW-1:2] * MinRecip;

  // hour * 60 as (hour * 64) - (hour * 4)
  assign hour_mins = {hour_q, 6'b0} - {4'b0, hour_q, 2'b0};
  assign min_diff  = mday_q - hour_mins;

  // 2100 is the only century year in range that is not a leap year
  assign leap = (year_q[1:0] == 2'b00) && (year_q != CenturyNoLeap);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_days(month_q, leap);

  assign status_o.year_fits  = (days_q < DaysW'(ylen));
  assign status_o.month_fits = (days_q < DaysW'(mlen)) || (month_q >= MonthDec);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q   <= local_t;
      year_q  <= EpochYear;
      month_q <= MonthJan;
    end else if (cmd_i.day_quo) begin
      days_q <= day_prod[DayShift +: DaysW];
    end else if (cmd_i.day_rem) begin
      rem_q <= rem_q - day_secs[TimeW-1:0];
    end else if (cmd_i.hour_split) begin
      hour_q <= hour_prod[HourShift +: HourW];
      mday_q <= mday_prod[MinShift +: MinOfDayW];
    end else if (cmd_i.min_split) begin
      min_q <= min_diff[MinuteW-1:0];
    end else if (cmd_i.year_step) begin
      days_q <= days_q - DaysW'(ylen);
      year_q <= year_q + 1'b1;
    end else if (cmd_i.month_step) begin
      days_q  <= days_q - DaysW'(mlen);
      month_q <= month_q + 1'b1;
    end
    if (cmd_i.publish) begin
      year_out_q  <= year_q;
      month_out_q <= month_q;
      day_out_q   <= days_q[DayW-1:0] + 1'b1;
      hour_out_q  <= hour_q;
      min_out_q   <= min_q;
    end
  end

  assign year_o   = year_out_q;
  assign month_o  = month_out_q;
  assign day_o    = day_out_q;
  assign hour_o   = hour_out_q;
  assign minute_o = min_out_q;

endmodule

>>> sv/epoch_seconds_to_date_core.sv
// Top level of the epoch-to-date converter: stream ports and configuration.
// Instantiates epsd_ctrl and epsd_datapath; uses epsd_pkg.
//
//   Channel   Direction  Payload (low bit up)                          Handshake
//   s_axis    in         tdata: epoch_seconds[31:0]                    tvalid/tready
//   m_axis    out        tdata: year[11:0] month[15:12] day[20:16]     tvalid/tready
//                               hour[25:21] minute[31:26]
//   cfg       in         cfg_wdata_i: zone_offset_seconds[16:0]        cfg_wen_i
//
// One timestamp is in work at a time. A beat is loaded, then passes through
// division by constants (day quotient, day remainder, hour and minute of day,
// minute within the hour), one step per whole year passed plus a final check,
// a step per month passed plus a final check, and a publish step that waits
// while the output register holds an untaken result. A finished result waits
// in the output register, so the next beat is taken while m_axis stalls; that
// next date then holds until the output register frees. Reset returns the
// offset to eight hours and clears all control state.
module epoch_seconds_to_date_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_wen_i,
  input  logic [epsd_pkg::OffsetW-1:0] cfg_wdata_i,   // zone_offset_seconds
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,  // epoch_seconds
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata   // year, month, day, hour, minute
);
  import epsd_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [DayW-1:0]    day;
  logic [HourW-1:0]   hour;
  logic [MinuteW-1:0] minute;

  // Sequence load, division, year and month stepping, then hold the result
  epsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  epsd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wen_i   (cfg_wen_i),
    .cfg_wdata_i (cfg_wdata_i),
    .epoch_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .year_o      (year),
    .month_o     (month),
    .day_o       (day),
    .hour_o      (hour),
    .minute_o    (minute)
  );

  // Pack the fields without gaps, year in the lowest bits
  assign m_axis_tdata = {minute, hour, day, month, year};

endmodule
